/* rtl/core/ktsd_pkg.sv */
// Shared types, character codes and helper functions for the knob token
// stream decoder. No dependencies; imported by every module of the block.

package ktsd_pkg;

  // Default limit on bytes held for one token before it is discarded
  localparam int DEFAULT_MAX_PENDING = 256;

  // Character codes
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CH_THREE = 8'h33;  // '3'
  localparam logic [7:0] CH_U     = 8'h55;  // 'U'
  localparam logic [7:0] CH_D     = 8'h44;  // 'D'
  localparam logic [7:0] CH_X     = 8'h58;  // 'X'
  localparam logic [7:0] CH_S     = 8'h53;  // 'S'
  localparam logic [7:0] CH_C     = 8'h43;  // 'C'
  localparam logic [7:0] CH_L     = 8'h4C;  // 'L'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Event kinds
  localparam logic KIND_ROTATION = 1'b0;
  localparam logic KIND_BUTTON   = 1'b1;

  // Press codes
  localparam logic [1:0] PRESS_SHORT = 2'd0;
  localparam logic [1:0] PRESS_CLICK = 2'd1;
  localparam logic [1:0] PRESS_LONG  = 2'd2;
  localparam logic [1:0] PRESS_NONE  = 2'd3;

  // Largest detent count accepted from the count text
  localparam logic [34:0] TICK_LIMIT = 35'h0_7FFF_FFFF;

  // Count parser result: value is meaningful only when ok is set
  typedef struct packed {
    logic        ok;
    logic [30:0] value;
  } ktsd_count_t;

  // One decoded event
  typedef struct packed {
    logic               kind;
    logic signed [31:0] ticks;
    logic [1:0]         button;
    logic [1:0]         press;
  } ktsd_event_t;

  // ASCII whitespace: space, tab, LF, VT, FF, CR
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Map a press letter to its code
  function automatic logic [1:0] press_code(input logic [7:0] c);
    logic [1:0] p;
    p = PRESS_NONE;
    if (c == CH_S) p = PRESS_SHORT;
    else if (c == CH_C) p = PRESS_CLICK;
    else if (c == CH_L) p = PRESS_LONG;
    return p;
  endfunction

endpackage

/* rtl/core/knob_token_stream_decoder.sv */
// Top level of the knob token stream decoder: input register, token
// tracker and result register. Depends on ktsd_pkg and ktsd_token_tracker.
//
// Usage:
//   Bytes enter on rx_valid / rx_ready / rx_byte, one transaction per byte.
//   Tokens end at ';' and are trimmed of ASCII whitespace. A token that
//   decodes to a rotation or button press gives one event transaction on
//   event_valid / event_ready with event_kind, ticks, button_number and
//   press_type; any other byte gives no transaction.
//   An event is presented once its ';' has passed through the input register
//   and then the result register; a stall of the receiver can hold the ';'
//   in the input register.
//   Throughput: one byte per cycle while the receiver keeps up; the rate is
//   set by the token state update between the two registers.
//   When the receiver stalls, the held event waits in the result register
//   and the input register still takes a byte; rx_ready then drops until
//   the event is taken.
//   Reset (rst, synchronous) empties both registers and clears the token
//   state. Tokens longer than MAX_PENDING bytes are discarded.

module knob_token_stream_decoder
  import ktsd_pkg::*;
#(
  parameter int MAX_PENDING = DEFAULT_MAX_PENDING
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_ready,
  input  logic [7:0]         rx_byte,
  output logic               event_valid,
  input  logic               event_ready,
  output logic               event_kind,
  output logic signed [31:0] ticks,
  output logic [1:0]         button_number,
  output logic [1:0]         press_type
);

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        advance;
  logic        fire;
  logic        hit;
  ktsd_event_t decoded;

  assign advance  = !event_valid || event_ready;
  assign rx_ready = !hold_valid || advance;
  assign fire     = hold_valid && advance;

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (rx_ready) begin
      hold_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ready && rx_valid) hold_byte <= rx_byte;
  end

  ktsd_token_tracker #(
    .MAX_PENDING (MAX_PENDING)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (fire),
    .rx_byte   (hold_byte),
    .hit       (hit),
    .event_out (decoded)
  );

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (advance) begin
      event_valid <= fire && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && hit) begin
      event_kind    <= decoded.kind;
      ticks         <= decoded.ticks;
      button_number <= decoded.button;
      press_type    <= decoded.press;
    end
  end

endmodule

/* rtl/core/ktsd_count_parser.sv */
// Decimal count parser for rotation tokens: optional blanks, '+', digits,
// blanks. Holds the phase and the running value. Depends on ktsd_pkg.

module ktsd_count_parser
  import ktsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output ktsd_count_t count
);

  localparam logic [2:0] PH_WAIT   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_TAIL   = 3'd3;
  localparam logic [2:0] PH_BAD    = 3'd4;

  logic [2:0]  phase, phase_next;
  logic [30:0] acc, acc_next;
  logic [34:0] scaled;
  logic        is_digit;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

  // Form acc * 10 + digit by shifts and adds
  assign scaled = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                + {31'd0, 4'(rx_byte - CH_ZERO)};

  // Advance the parser by one byte
  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    if (is_blank(rx_byte)) begin
      unique case (phase)
        PH_SIGN:   phase_next = PH_BAD;
        PH_DIGITS: phase_next = PH_TAIL;
        default:   phase_next = phase;
      endcase
    end else if (rx_byte == CH_PLUS) begin
      phase_next = (phase == PH_WAIT) ? PH_SIGN : PH_BAD;
    end else if (is_digit) begin
      unique case (phase) inside
        PH_WAIT, PH_SIGN, PH_DIGITS: begin
          if (scaled > TICK_LIMIT) begin
            phase_next = PH_BAD;
          end else begin
            phase_next = PH_DIGITS;
            acc_next   = scaled[30:0];
          end
        end
        default: phase_next = PH_BAD;
      endcase
    end else begin
      phase_next = PH_BAD;
    end
  end

  // Hold or clear the parser state
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase <= PH_WAIT;
      acc   <= '0;
    end else if (step) begin
      phase <= phase_next;
      acc   <= acc_next;
    end
  end

  // A usable count needs digits and a non-zero value
  assign count.ok    = ((phase == PH_DIGITS) || (phase == PH_TAIL)) && (acc != '0);
  assign count.value = acc;

endmodule

/* rtl/core/ktsd_token_tracker.sv */
// Token state for the decoder: trimming, kept characters, overlong discard
// and the decode at each ';'. Depends on ktsd_pkg and ktsd_count_parser.

module ktsd_token_tracker
  import ktsd_pkg::*;
#(
  parameter int MAX_PENDING = DEFAULT_MAX_PENDING
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output logic        hit,
  output ktsd_event_t event_out
);

  localparam int CNT_W = $clog2(MAX_PENDING + 1);

  logic [CNT_W-1:0] pending_count;
  logic             content_started;
  logic [7:0]       lead_char;
  logic [7:0]       second_char;
  logic [7:0]       third_char;
  logic [CNT_W-1:0] content_length;
  logic [CNT_W-1:0] trailing_space_run;

  logic             is_semi;
  logic             blank;
  logic             overflow;
  logic             clear;
  logic             lead_ud;
  logic [CNT_W-1:0] pos;
  ktsd_count_t      count;
  logic [31:0]      magnitude;
  logic [1:0]       third_press;
  logic [1:0]       lead_press;

  assign is_semi  = (rx_byte == CH_SEMI);
  assign blank    = is_blank(rx_byte);
  assign overflow = (pending_count == CNT_W'(MAX_PENDING));
  assign clear    = step && (is_semi || overflow);
  assign lead_ud  = (lead_char == CH_U) || (lead_char == CH_D);
  assign pos      = content_length + trailing_space_run;

  ktsd_count_parser u_count (
    .clk     (clk),
    .rst     (rst),
    .clear   (clear),
    .step    (step && !is_semi && content_started && lead_ud),
    .rx_byte (rx_byte),
    .count   (count)
  );

  // Track trimmed content and the first three characters
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pending_count      <= '0;
      content_started    <= 1'b0;
      lead_char          <= '0;
      second_char        <= '0;
      third_char         <= '0;
      content_length     <= '0;
      trailing_space_run <= '0;
    end else if (step) begin
      pending_count <= pending_count + CNT_W'(1);
      if (content_started) begin
        if (pos == CNT_W'(1)) second_char <= rx_byte;
        if (pos == CNT_W'(2)) third_char <= rx_byte;
        if (blank) begin
          trailing_space_run <= trailing_space_run + CNT_W'(1);
        end else begin
          content_length     <= pos + CNT_W'(1);
          trailing_space_run <= '0;
        end
      end else if (!blank) begin
        content_started    <= 1'b1;
        lead_char          <= rx_byte;
        content_length     <= CNT_W'(1);
        trailing_space_run <= '0;
      end
    end
  end

  assign magnitude   = count.ok ? {1'b0, count.value} : 32'd1;
  assign third_press = press_code(third_char);
  assign lead_press  = press_code(lead_char);

  // Decode the finished token when its ';' arrives
  always_comb begin
    hit              = 1'b0;
    event_out.kind   = KIND_ROTATION;
    event_out.ticks  = '0;
    event_out.button = '0;
    event_out.press  = PRESS_SHORT;
    if (content_started) begin
      if (lead_ud) begin
        hit             = 1'b1;
        event_out.ticks = (lead_char == CH_U) ? $signed(magnitude) : -$signed(magnitude);
      end else if ((lead_char == CH_X) && (content_length >= CNT_W'(3))) begin
        if ((second_char >= CH_ONE) && (second_char <= CH_THREE)
            && (third_press != PRESS_NONE)) begin
          hit              = 1'b1;
          event_out.kind   = KIND_BUTTON;
          event_out.button = 2'(second_char - CH_ZERO);
          event_out.press  = third_press;
        end
      end else if ((content_length == CNT_W'(1)) && (lead_press != PRESS_NONE)) begin
        hit             = 1'b1;
        event_out.kind  = KIND_BUTTON;
        event_out.press = lead_press;
      end
    end
    hit = hit && is_semi;
  end

endmodule

/* sim/tb_knob_token_stream_decoder.sv */
// Self-checking testbench for knob_token_stream_decoder: a directed token table,
// then random token streams under bursty input and stalling output.
// Depends on ktsd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_knob_token_stream_decoder;
  import ktsd_pkg::*;

  localparam int TOKEN_LIMIT  = DEFAULT_MAX_PENDING;
  localparam int RANDOM_BYTES = 1600;
  localparam int DIR_ROWS     = 25;

  typedef enum logic [2:0] {CNT_WAIT, CNT_SIGN, CNT_DIGITS, CNT_TAIL, CNT_BAD} count_phase_t;
  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_TYPED} row_check_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               rx_valid = 1'b0;
  logic               rx_ready;
  logic [7:0]         rx_byte = 8'h00;
  logic               event_valid;
  logic               event_ready = 1'b0;
  logic               event_kind;
  logic signed [31:0] ticks;
  logic [1:0]         button_number;
  logic [1:0]         press_type;

  // Token decoder shadow state
  logic [8:0]   tok_pending;
  logic         tok_started;
  logic [7:0]   tok_c0, tok_c1, tok_c2;
  logic [8:0]   tok_body;
  logic [8:0]   tok_blank_run;
  logic [31:0]  tok_count;
  count_phase_t tok_phase;

  ktsd_event_t pending_events[$];
  logic [7:0]  tok_bytes[$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          hold_req = 0;

  // Directed token table
  string dir_text [DIR_ROWS] = '{
    "U;", "D;", "U2147483647;", "D2147483647;", "U2147483648;",
    "U0;", "D-5;", "U+;", " \tU +42 \r\n;", "D 7 8;",
    "U12x;", "X1S;", "X2C;", "X3L;", "X4S;",
    "X1;", "X2Lq;", "S;", "C;", "L;",
    "SL;", ";", " \t\n ;", "Q\377;", "X 1S;"
  };
  row_check_t dir_check [DIR_ROWS] = '{
    ROW_TYPED, ROW_TYPED, ROW_TYPED, ROW_TYPED, ROW_TYPED,
    ROW_TYPED, ROW_TYPED, ROW_TYPED, ROW_PREDICT, ROW_PREDICT,
    ROW_PREDICT, ROW_TYPED, ROW_TYPED, ROW_TYPED, ROW_SILENT,
    ROW_SILENT, ROW_PREDICT, ROW_TYPED, ROW_TYPED, ROW_TYPED,
    ROW_SILENT, ROW_SILENT, ROW_SILENT, ROW_SILENT, ROW_PREDICT
  };
  ktsd_event_t dir_event [DIR_ROWS] = '{
    {KIND_ROTATION, 32'sd1, 2'd0, PRESS_SHORT},
    {KIND_ROTATION, -32'sd1, 2'd0, PRESS_SHORT},
    {KIND_ROTATION, 32'sh7FFF_FFFF, 2'd0, PRESS_SHORT},
    {KIND_ROTATION, 32'sh8000_0001, 2'd0, PRESS_SHORT},
    {KIND_ROTATION, 32'sd1, 2'd0, PRESS_SHORT},
    {KIND_ROTATION, 32'sd1, 2'd0, PRESS_SHORT},
    {KIND_ROTATION, -32'sd1, 2'd0, PRESS_SHORT},
    {KIND_ROTATION, 32'sd1, 2'd0, PRESS_SHORT},
    '0, '0, '0,
    {KIND_BUTTON, 32'sd0, 2'd1, PRESS_SHORT},
    {KIND_BUTTON, 32'sd0, 2'd2, PRESS_CLICK},
    {KIND_BUTTON, 32'sd0, 2'd3, PRESS_LONG},
    '0, '0, '0,
    {KIND_BUTTON, 32'sd0, 2'd0, PRESS_SHORT},
    {KIND_BUTTON, 32'sd0, 2'd0, PRESS_CLICK},
    {KIND_BUTTON, 32'sd0, 2'd0, PRESS_LONG},
    '0, '0, '0, '0, '0
  };

  knob_token_stream_decoder #(
    .MAX_PENDING(TOKEN_LIMIT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .rx_byte      (rx_byte),
    .event_valid  (event_valid),
    .event_ready  (event_ready),
    .event_kind   (event_kind),
    .ticks        (ticks),
    .button_number(button_number),
    .press_type   (press_type)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous ceiling on the whole run
  initial begin
    #3_000_000;
    $display("tb_knob_token_stream_decoder failed");
    $finish;
  end

  function automatic bit blank_byte(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [1:0] press_of(input logic [7:0] c);
    case (c)
      CH_S:    return PRESS_SHORT;
      CH_C:    return PRESS_CLICK;
      CH_L:    return PRESS_LONG;
      default: return PRESS_NONE;
    endcase
  endfunction

  function automatic void clear_token_state();
    tok_pending   = '0;
    tok_started   = 1'b0;
    tok_c0        = '0;
    tok_c1        = '0;
    tok_c2        = '0;
    tok_body      = '0;
    tok_blank_run = '0;
    tok_count     = '0;
    tok_phase     = CNT_WAIT;
  endfunction

  // Advance the count parser that follows a leading U or D
  function automatic void advance_count(input logic [7:0] c);
    logic [35:0] v;
    if (blank_byte(c)) begin
      if (tok_phase == CNT_SIGN) tok_phase = CNT_BAD;
      else if (tok_phase == CNT_DIGITS) tok_phase = CNT_TAIL;
    end else if (c == CH_PLUS) begin
      tok_phase = (tok_phase == CNT_WAIT) ? CNT_SIGN : CNT_BAD;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      if (tok_phase == CNT_WAIT || tok_phase == CNT_SIGN || tok_phase == CNT_DIGITS) begin
        v = 36'(tok_count) * 36'd10 + 36'(c - CH_ZERO);
        if (v > 36'h0_7FFF_FFFF) begin
          tok_phase = CNT_BAD;
        end else begin
          tok_count = v[31:0];
          tok_phase = CNT_DIGITS;
        end
      end else begin
        tok_phase = CNT_BAD;
      end
    end else begin
      tok_phase = CNT_BAD;
    end
  endfunction

  // Decode the trimmed token held so far; return 1 when it names an event
  function automatic bit finish_token(output ktsd_event_t ev);
    logic [31:0] count;
    logic [1:0]  p;
    ev = '0;
    if (!tok_started || tok_body == 0) return 1'b0;
    if (tok_c0 == CH_U || tok_c0 == CH_D) begin
      count = 32'd1;
      if ((tok_phase == CNT_DIGITS || tok_phase == CNT_TAIL) && tok_count != 0)
        count = tok_count;
      ev.kind  = KIND_ROTATION;
      ev.ticks = (tok_c0 == CH_U) ? count : (32'd0 - count);
      return 1'b1;
    end
    if (tok_c0 == CH_X && tok_body >= 3) begin
      p = press_of(tok_c2);
      if (tok_c1 < CH_ONE || tok_c1 > CH_THREE || p == PRESS_NONE) return 1'b0;
      ev.kind   = KIND_BUTTON;
      ev.button = 2'(tok_c1 - CH_ZERO);
      ev.press  = p;
      return 1'b1;
    end
    if (tok_body == 1 && press_of(tok_c0) != PRESS_NONE) begin
      ev.kind  = KIND_BUTTON;
      ev.press = press_of(tok_c0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Take one byte into the shadow state; return 1 with the event it completes
  function automatic bit decode_byte(input logic [7:0] b, output ktsd_event_t ev);
    logic [8:0] pos;
    bit         got;
    ev  = '0;
    got = 1'b0;
    if (b == CH_SEMI) begin
      got = finish_token(ev);
      clear_token_state();
    end else begin
      if (tok_started) begin
        pos = tok_body + tok_blank_run;
        if (pos == 1) tok_c1 = b;
        else if (pos == 2) tok_c2 = b;
        if (tok_c0 == CH_U || tok_c0 == CH_D) advance_count(b);
        if (blank_byte(b)) begin
          tok_blank_run = tok_blank_run + 1'b1;
        end else begin
          tok_body      = pos + 1'b1;
          tok_blank_run = '0;
        end
      end else if (!blank_byte(b)) begin
        tok_started   = 1'b1;
        tok_c0        = b;
        tok_body      = 9'd1;
        tok_blank_run = '0;
      end
      tok_pending = tok_pending + 1'b1;
      // Drop an overlong token and start afresh
      if (tok_pending > TOKEN_LIMIT) clear_token_state();
    end
    return got;
  endfunction

  // Offer one byte in bursts with random gaps; predict once it is taken
  task automatic send_byte(input logic [7:0] b, output bit got, output ktsd_event_t ev);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        rx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    burst_left--;
    items_sent++;
    got = decode_byte(b, ev);
  endtask

  task automatic send_token_bytes();
    bit          got;
    ktsd_event_t ev;
    foreach (tok_bytes[i]) begin
      send_byte(tok_bytes[i], got, ev);
      if (got) pending_events.push_back(ev);
    end
  endtask

  // Hold the input idle until every predicted event has been taken
  task automatic drain_events();
    rx_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) tok_bytes.push_back(s[i]);
  endfunction

  function automatic void add_blanks(input int n);
    logic [7:0] c;
    repeat (n) begin
      c = ($urandom_range(0, 1) == 0) ? CH_SPACE : 8'($urandom_range(9, 13));
      tok_bytes.push_back(c);
    end
  endfunction

  function automatic logic [7:0] any_but_semi();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_SEMI) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] press_letter();
    case ($urandom_range(0, 2))
      0:       return CH_S;
      1:       return CH_C;
      default: return CH_L;
    endcase
  endfunction

  // Build one random token, mostly well formed, ending in ';' unless overlong
  function automatic void build_token();
    int          sel;
    int          n;
    logic [31:0] val;
    tok_bytes.delete();
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      // rotation with assorted count text
      add_blanks($urandom_range(0, 2));
      tok_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_U : CH_D);
      add_blanks($urandom_range(0, 2));
      n = $urandom_range(0, 9);
      if (n != 0) begin
        if (n == 1) tok_bytes.push_back(CH_PLUS);
        if (n == 9) tok_bytes.push_back(any_but_semi());
        if (n == 7) val = $urandom_range(32'h7FFF_FF00, 32'h7FFF_FFFF);
        else if (n == 8) val = $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
        else if ($urandom_range(0, 9) == 0) val = 0;
        else val = $urandom_range(1, 999);
        if ($urandom_range(0, 7) == 0) add_text("00");
        add_text($sformatf("%0d", val));
        if ($urandom_range(0, 5) == 0) begin
          add_blanks(1);
          tok_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
      end
      add_blanks($urandom_range(0, 2));
      tok_bytes.push_back(CH_SEMI);
    end else if (sel < 55) begin
      // aux button
      add_blanks($urandom_range(0, 2));
      tok_bytes.push_back(CH_X);
      n = $urandom_range(0, 5);
      if (n != 0) begin
        tok_bytes.push_back(($urandom_range(0, 4) == 0) ? any_but_semi()
                                                        : 8'(CH_ONE + $urandom_range(0, 2)));
        if (n != 1)
          tok_bytes.push_back(($urandom_range(0, 4) == 0) ? any_but_semi() : press_letter());
      end
      if ($urandom_range(0, 4) == 0) tok_bytes.push_back(any_but_semi());
      add_blanks($urandom_range(0, 2));
      tok_bytes.push_back(CH_SEMI);
    end else if (sel < 75) begin
      // centre switch
      add_blanks($urandom_range(0, 2));
      tok_bytes.push_back(press_letter());
      if ($urandom_range(0, 4) == 0) tok_bytes.push_back(any_but_semi());
      add_blanks($urandom_range(0, 2));
      tok_bytes.push_back(CH_SEMI);
    end else if (sel < 90) begin
      // noise over the full byte range
      repeat ($urandom_range(1, 8)) tok_bytes.push_back(8'($urandom_range(0, 255)));
      tok_bytes.push_back(CH_SEMI);
    end else if (sel < 97) begin
      add_blanks($urandom_range(0, 3));
      tok_bytes.push_back(CH_SEMI);
    end else begin
      // overlong run straddling the pending limit
      tok_bytes.push_back(CH_U);
      n = $urandom_range(TOKEN_LIMIT - 6, TOKEN_LIMIT + 6);
      repeat (n) begin
        case ($urandom_range(0, 2))
          0:       add_blanks(1);
          1:       tok_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
          default: tok_bytes.push_back(any_but_semi());
        endcase
      end
      if ($urandom_range(0, 1) == 0) tok_bytes.push_back(CH_SEMI);
    end
  endfunction

  // Receiver: shifting stall pattern, plus a long hold-off on request
  initial begin
    logic [31:0] cyc;
    int          hold_left;
    cyc       = '0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      cyc = cyc + 1;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        event_ready <= 1'b0;
      end else begin
        case (cyc[9:8])
          2'd0:    event_ready <= 1'b1;
          2'd1:    event_ready <= ($urandom_range(0, 3) != 0);
          2'd2:    event_ready <= ($urandom_range(0, 3) == 0);
          default: event_ready <= ((cyc % 7) < 3);
        endcase
      end
    end
  end

  // Check each event transaction against the oldest prediction
  always @(posedge clk) begin
    ktsd_event_t want;
    if (!rst && event_valid && event_ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event kind %0d ticks %0d button %0d press %0d",
                 $time, event_kind, ticks, button_number, press_type);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind) begin
          $display("%0t: event_kind expected %0d got %0d", $time, want.kind, event_kind);
          mismatch_count++;
        end
        if (ticks !== want.ticks) begin
          $display("%0t: ticks expected %0d got %0d", $time, want.ticks, ticks);
          mismatch_count++;
        end
        if (button_number !== want.button) begin
          $display("%0t: button_number expected %0d got %0d",
                   $time, want.button, button_number);
          mismatch_count++;
        end
        if (press_type !== want.press) begin
          $display("%0t: press_type expected %0d got %0d", $time, want.press, press_type);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    bit          got;
    ktsd_event_t ev;
    int          random_start;
    bit          hold_done;
    bit          pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    clear_token_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      for (int i = 0; i < dir_text[r].len(); i++) begin
        send_byte(dir_text[r][i], got, ev);
        if (dir_text[r][i] == CH_SEMI) begin
          case (dir_check[r])
            ROW_PREDICT: if (got) pending_events.push_back(ev);
            ROW_TYPED:   pending_events.push_back(dir_event[r]);
            default:     ;
          endcase
        end
      end
    end
    drain_events();

    // Random token streams
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_BYTES) begin
      if (!hold_done && items_sent - random_start >= 500) begin
        // hold the receiver off and push fifteen presses so that the input backs up
        hold_done = 1'b1;
        hold_req  = 1'b1;
        repeat (15) begin
          tok_bytes.delete();
          add_text("S;");
          send_token_bytes();
        end
      end
      if (!pause_done && items_sent - random_start >= 1100) begin
        pause_done = 1'b1;
        drain_events();
      end
      build_token();
      send_token_bytes();
    end

    rx_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_knob_token_stream_decoder passed");
    else
      $display("tb_knob_token_stream_decoder failed");
    $finish;
  end

endmodule
